[hw/rtl/nearest_point_match_top_macros.svh]
// ----------------------------------------------------------------------------
// Nearest point match assertion macros
// Shared property forms for the checker of the nearest point match block.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_MATCH_TOP_MACROS_SVH
`define NEAREST_POINT_MATCH_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/npm_pkg.sv]
// ----------------------------------------------------------------------------
// Nearest point match package
// Types and fixed constants shared by the nearest point match modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package npm_pkg;

  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned DIFF_W     = COORD_BITS + 1;
  localparam int unsigned SQ_W       = 2 * DIFF_W;
  localparam int unsigned DIST_W     = 52;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned NIDX_W     = 10;

  // Configuration port: one 64-bit register at byte offset 8*index.
  localparam int unsigned PADDR_W     = 4;
  localparam int unsigned PDATA_W     = 64;
  localparam int unsigned REG_IDX_BIT = 3;
  localparam logic        REG_MAX_DIST_SQ = 1'b0;

  localparam logic [DIST_W-1:0] DIST_ALL_ONES = '1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } npm_op_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } npm_point_t;

  typedef struct packed {
    npm_op_e            op;
    coord_t             coord_x;
    coord_t             coord_y;
    coord_t             coord_z;
    logic [TAG_W-1:0]   query_tag;
  } npm_req_t;

  typedef struct packed {
    logic [TAG_W-1:0]   result_tag;
    logic               matched;
    logic [NIDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0]  nearest_distance_sq;
  } npm_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/nearest_point_match_top.sv]
// Sequence: an accepted query starts a scan that reads each of the N stored points from
//   the table RAM, none on an empty table; loads and clears are done directly in idle.
// Throughput: one table RAM read per cycle during a scan, a read and distance pipe, then
//   back to idle; a new request is taken only once the last query is through. A stalled
//   result holds off the next request; loads and clears are taken every idle cycle.
// Reset: point count cleared, threshold set to all ones, table contents undefined.
// ----------------------------------------------------------------------------
// Nearest point match top level
// Brute-force nearest-neighbor search over a RAM of signed Q8.16 3-D points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nearest_point_match_top
  import npm_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  npm_req_t           in_req_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output npm_rsp_t           out_rsp_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;  // take requests
  localparam logic [1:0] ST_SCAN = 2'd1;  // stream the table through the distance pipe
  localparam logic [1:0] ST_DONE = 2'd2;  // park the result until the output register frees

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q;      // points stored since the last clear
  logic [CNT_W-1:0]  issue_q;      // next table entry to read during a scan
  logic              rd_valid_q;   // RAM read data valid this cycle
  logic [IDX_W-1:0]  rd_idx_q;
  npm_point_t        query_q;
  logic [TAG_W-1:0]  tag_q;
  logic [DIST_W-1:0] best_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [DIST_W-1:0] thr_q;
  logic              out_valid_q;
  npm_rsp_t          out_q;

  logic              in_fire, is_load, is_query, is_clear;
  logic              load_we, issue, scan_end, out_free, out_load;
  logic              cfg_we;
  npm_point_t        wr_point, rd_point;
  logic              dist_busy, sum_valid;
  logic [IDX_W-1:0]  sum_idx;
  logic [DIST_W-1:0] sum;
  logic [IDX_W+NIDX_W-1:0] best_idx_ext;

  // ---------------------------------------------------------------------------
  // Request decode. Requests are taken only while idle, so a load never
  // overlaps a scan and the RAM needs no forwarding.
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_load    = in_fire && (in_req_i.op == OP_LOAD);
  assign is_query   = in_fire && (in_req_i.op == OP_QUERY);
  assign is_clear   = in_fire && (in_req_i.op == OP_CLEAR);
  // Drop loads once the table is full.
  assign load_we    = is_load && (count_q != MAX_CNT);

  assign wr_point.x = in_req_i.coord_x;
  assign wr_point.y = in_req_i.coord_y;
  assign wr_point.z = in_req_i.coord_z;

  // ---------------------------------------------------------------------------
  // Scan control: one RAM read per cycle, then drain the distance pipe.
  // ---------------------------------------------------------------------------
  assign issue    = (state_q == ST_SCAN) && (issue_q != count_q);
  assign scan_end = (state_q == ST_SCAN) && !issue && !rd_valid_q && !dist_busy;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == ST_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (is_query) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  npm_ram #(
    .WIDTH($bits(npm_point_t)),
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i(wr_point),
    .re_i   (issue),
    .raddr_i(issue_q[IDX_W-1:0]),
    .rdata_o(rd_point)
  );

  npm_dist #(
    .IDX_W(IDX_W)
  ) u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_valid_i (rd_valid_q),
    .rd_idx_i   (rd_idx_q),
    .target_i   (rd_point),
    .query_i    (query_q),
    .busy_o     (dist_busy),
    .sum_valid_o(sum_valid),
    .sum_idx_o  (sum_idx),
    .sum_o      (sum)
  );

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= DIST_ALL_ONES;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= issue;
      if (is_clear) begin
        count_q <= '0;
      end else if (load_we) begin
        count_q <= count_q + 1'b1;
      end
      if (is_query) begin
        issue_q <= '0;
      end else if (issue) begin
        issue_q <= issue_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we) begin
        thr_q <= pwdata[DIST_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers. The empty-table answer (all ones, index 0) falls out of
  // the start value, and a strict compare keeps the lowest index on a tie.
  // ---------------------------------------------------------------------------
  assign best_idx_ext = {{NIDX_W{1'b0}}, best_idx_q};

  always_ff @(posedge clk_i) begin
    rd_idx_q <= issue_q[IDX_W-1:0];
    if (is_query) begin
      query_q.x  <= in_req_i.coord_x;
      query_q.y  <= in_req_i.coord_y;
      query_q.z  <= in_req_i.coord_z;
      tag_q      <= in_req_i.query_tag;
      best_q     <= DIST_ALL_ONES;
      best_idx_q <= '0;
    end else if (sum_valid && (sum < best_q)) begin
      best_q     <= sum;
      best_idx_q <= sum_idx;
    end
    if (out_load) begin
      out_q.result_tag          <= tag_q;
      // An empty table leaves best at all ones, which is never below the threshold.
      out_q.matched             <= (best_q < thr_q);
      out_q.nearest_index       <= best_idx_ext[NIDX_W-1:0];
      out_q.nearest_distance_sq <= best_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // ---------------------------------------------------------------------------
  // Configuration port: write in the access phase, no wait states.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready
                  && (paddr[REG_IDX_BIT] == REG_MAX_DIST_SQ);
  assign prdata = (paddr[REG_IDX_BIT] == REG_MAX_DIST_SQ) ? PDATA_W'(thr_q) : '0;

endmodule

`default_nettype wire

[hw/rtl/npm_ram.sv]
// ----------------------------------------------------------------------------
// Nearest point match RAM
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npm_ram #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/npm_dist.sv]
// ----------------------------------------------------------------------------
// Nearest point match distance pipeline
// Three-stage squared Euclidean distance between a stored and a query point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npm_dist
  import npm_pkg::*;
#(
  parameter int unsigned IDX_W = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_valid_i,
  input  logic [IDX_W-1:0]  rd_idx_i,
  input  npm_point_t        target_i,
  input  npm_point_t        query_i,
  output logic              busy_o,
  output logic              sum_valid_o,
  output logic [IDX_W-1:0]  sum_idx_o,
  output logic [DIST_W-1:0] sum_o
);

  function automatic logic [DIFF_W-1:0] abs_diff(input coord_t a, input coord_t b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  logic [2:0]        valid_q;
  logic [IDX_W-1:0]  idx_q [3];
  logic [DIFF_W-1:0] mag_x_q, mag_y_q, mag_z_q;
  logic [SQ_W-1:0]   sq_x_q, sq_y_q, sq_z_q;
  logic [SQ_W-1:0]   sq_x_d, sq_y_d, sq_z_d;
  logic [DIST_W-1:0] sum_q;

  assign sq_x_d = SQ_W'(mag_x_q) * SQ_W'(mag_x_q);
  assign sq_y_d = SQ_W'(mag_y_q) * SQ_W'(mag_y_q);
  assign sq_z_d = SQ_W'(mag_z_q) * SQ_W'(mag_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], rd_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    mag_x_q  <= abs_diff(target_i.x, query_i.x);
    mag_y_q  <= abs_diff(target_i.y, query_i.y);
    mag_z_q  <= abs_diff(target_i.z, query_i.z);
    idx_q[0] <= rd_idx_i;
    sq_x_q   <= sq_x_d;
    sq_y_q   <= sq_y_d;
    sq_z_q   <= sq_z_d;
    idx_q[1] <= idx_q[0];
    sum_q    <= DIST_W'(sq_x_q) + DIST_W'(sq_y_q) + DIST_W'(sq_z_q);
    idx_q[2] <= idx_q[1];
  end

  assign busy_o      = |valid_q;
  assign sum_valid_o = valid_q[2];
  assign sum_idx_o   = idx_q[2];
  assign sum_o       = sum_q;

endmodule

`default_nettype wire

[hw/rtl/npm_checker.sv]
// ----------------------------------------------------------------------------
// Nearest point match checker
// Port-level assertions for the nearest point match block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_point_match_top_macros.svh"

module npm_checker
  import npm_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input npm_req_t in_req_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input npm_rsp_t out_rsp_i
);

  // A stalled result holds.
  `NPM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_rsp_i), "result dropped or changed while stalled")

  // A query blocks further requests until its result is parked.
  `NPM_ASSERT_NEXT(a_query_blocks, clk_i, rst_ni,
    in_valid_i && in_ready_i && (in_req_i.op == OP_QUERY),
    !in_ready_i, "request taken while a query scan runs")

  // A new result only appears at the end of a scan.
  `NPM_ASSERT_NOW(a_result_after_scan, clk_i, rst_ni, $rose(out_valid_i),
    $past(!in_ready_i), "result appeared without a query in flight")

  // A match always carries a real distance.
  `NPM_ASSERT_NOW(a_match_distance, clk_i, rst_ni, out_valid_i && out_rsp_i.matched,
    out_rsp_i.nearest_distance_sq != DIST_ALL_ONES, "match reported on empty table")

endmodule

bind nearest_point_match_top npm_checker u_npm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_i (in_ready_o),
  .in_req_i   (in_req_i),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_i  (out_rsp_o)
);

`default_nettype wire
